FILE: src/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants for the current moving average block.
// ----------------------------------------------------------------------------
package cma_pkg;

    localparam int SAMPLE_W = 16;
    localparam int THR_W    = 15;

    localparam logic [THR_W-1:0] THR_RESET = 15'd50;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [THR_W-1:0]           thresh_t;

endpackage

FILE: src/cma_ring.sv
// ----------------------------------------------------------------------------
// cma_ring
// Sample ring: simple dual-port synchronous RAM, one read and one write
// port, registered read data.
// ----------------------------------------------------------------------------
module cma_ring #(
    parameter int DEPTH = 60,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output cma_pkg::sample_t rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  cma_pkg::sample_t wr_data
);
    import cma_pkg::*;

    sample_t mem [DEPTH];
    sample_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/cma_div.sv
// ----------------------------------------------------------------------------
// cma_div
// Restoring serial divider, unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cma_div #(
    parameter int NW = 22,
    parameter int DW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);
    import cma_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg, quo_reg[NW-1]};
        rem_sub   = rem_sh - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sub[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/current_moving_average.sv
// ----------------------------------------------------------------------------
// current_moving_average
// Boxcar running mean of signed current samples, ring kept in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : current_ma with in_valid / in_stall. An item is taken
//                    when in_valid is high and in_stall is low.
//   Output channel : average_ma with out_valid / out_stall, one result per
//                    input item, held steady while out_stall is high.
//   Config         : cfg_wr_en / cfg_wr_data write restart_threshold; write
//                    only while no item is in flight.
//   Path           : the ring RAM read is registered, then the serial
//                    divider works out one quotient bit per step and
//                    flags done; the mean then goes to the output
//                    register. A restart item skips the divider.
//   Flow           : one item at a time; in_stall is high from accept until
//                    the result is loaded in the output register, so the next
//                    item is taken only after that.
//   Stall          : a result waiting on out_stall does not block the next
//                    accept; only a second finished result waits for it.
//   Reset          : sum, index, full flag, last mean and output valid clear;
//                    threshold returns to 50. Ring RAM is not cleared: it is
//                    only read after every entry has been written.
// ----------------------------------------------------------------------------
module current_moving_average #(
    parameter int WINDOW = 60
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  cma_pkg::sample_t current_ma,
    output logic             out_valid,
    input  logic             out_stall,
    output cma_pkg::sample_t average_ma,
    input  logic             cfg_wr_en,
    input  cma_pkg::thresh_t cfg_wr_data
);
    import cma_pkg::*;

    localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int IW    = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + 1 + $clog2(WINDOW);
    localparam int MAG_W = SUM_W - 1;
    localparam int MAGS_W = SAMPLE_W + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    thresh_t thr_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic            full_reg, full_next;
    sample_t         mean_reg, mean_next;
    logic            restart_reg, restart_next;
    logic            wrap_reg, wrap_next;
    sample_t         samp_reg, samp_next;
    logic            neg_reg, neg_next;
    logic            oval_reg, oval_next;
    sample_t         oavg_reg, oavg_next;

    logic            accept;
    logic [MAGS_W-1:0] mag_mean, mag_samp, thr_ext;
    logic [IW-1:0]   base_idx;
    logic [IW-1:0]   new_idx;
    sample_t         old_samp;
    logic signed [SUM_W-1:0] sum_calc;
    logic [SUM_W-1:0] sum_neg;

    logic            ring_rd_en;
    logic            ring_wr_en;
    logic            div_start;
    logic            div_done;
    logic [MAG_W-1:0] div_dividend;
    logic [IW-1:0]   div_divisor;
    logic [MAG_W-1:0] div_quo;
    logic [SAMPLE_W-1:0] quo_lo;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // |x| with -32768 mapping to 32768
    assign mag_mean = mean_reg[SAMPLE_W-1] ? (MAGS_W'(0) - MAGS_W'(mean_reg))
                                           : MAGS_W'(mean_reg);
    assign mag_samp = current_ma[SAMPLE_W-1] ? (MAGS_W'(0) - MAGS_W'(current_ma))
                                             : MAGS_W'(current_ma);
    assign thr_ext  = MAGS_W'(thr_reg);

    // once full, an index that reached WINDOW wraps before use
    assign base_idx = (idx_reg == IW'(WINDOW)) ? '0 : idx_reg;
    assign new_idx  = (full_reg ? base_idx : idx_reg) + IW'(1);

    assign sum_calc = full_reg
                    ? (sum_reg + SUM_W'(samp_reg) - SUM_W'(old_samp))
                    : (sum_reg + SUM_W'(samp_reg));
    assign sum_neg  = SUM_W'(0) - sum_calc;

    assign quo_lo   = div_quo[SAMPLE_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        idx_next     = idx_reg;
        full_next    = full_reg;
        mean_next    = mean_reg;
        restart_next = restart_reg;
        wrap_next    = wrap_reg;
        samp_next    = samp_reg;
        neg_next     = neg_reg;
        ring_rd_en   = 1'b0;
        ring_wr_en   = 1'b0;
        div_start    = 1'b0;
        div_dividend = sum_calc[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_calc[MAG_W-1:0];
        div_divisor  = full_next ? IW'(WINDOW) : new_idx;
        oval_next    = oval_reg && out_stall;
        oavg_next    = oavg_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    samp_next    = current_ma;
                    restart_next = (mag_mean < thr_ext) && (mag_samp > thr_ext);
                    wrap_next    = full_reg;
                    ring_rd_en   = full_reg;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                if (restart_reg)
                begin
                    idx_next   = '0;
                    full_next  = 1'b0;
                    sum_next   = '0;
                    mean_next  = samp_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    ring_wr_en = 1'b1;
                    idx_next   = new_idx;
                    full_next  = full_reg || (new_idx == IW'(WINDOW));
                    sum_next   = sum_calc;
                    neg_next   = sum_calc[SUM_W-1];
                    div_start  = 1'b1;
                    div_divisor = full_reg ? IW'(WINDOW) : new_idx;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    mean_next  = neg_reg ? (SAMPLE_W'(0) - quo_lo) : quo_lo;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!oval_reg || !out_stall)
                begin
                    oval_next  = 1'b1;
                    oavg_next  = mean_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            thr_reg   <= THR_RESET;
            sum_reg   <= '0;
            idx_reg   <= '0;
            full_reg  <= 1'b0;
            mean_reg  <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            sum_reg  <= sum_next;
            idx_reg  <= idx_next;
            full_reg <= full_next;
            mean_reg <= mean_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        restart_reg <= restart_next;
        wrap_reg    <= wrap_next;
        samp_reg    <= samp_next;
        neg_reg     <= neg_next;
        oavg_reg    <= oavg_next;
    end

    // ring is read at the accept edge (once full) and written back in the S_READ cycle that follows
    cma_ring #(
        .DEPTH (WINDOW),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .rd_en   (ring_rd_en),
        .rd_addr (base_idx[AW-1:0]),
        .rd_data (old_samp),
        .wr_en   (ring_wr_en),
        .wr_addr (wrap_reg ? base_idx[AW-1:0] : idx_reg[AW-1:0]),
        .wr_data (samp_reg)
    );

    cma_div #(
        .NW (MAG_W),
        .DW (IW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid  = oval_reg;
    assign average_ma = oavg_reg;

endmodule

FILE: dv/tb_current_moving_average.sv
// ----------------------------------------------------------------------------
// tb_current_moving_average
// Self-checking bench for the boxcar running mean of signed current samples.
// Every accepted sample is run through a cycle-free model of the ring, sum,
// index and restart logic, and the predicted mean is queued. Each accepted
// average is compared against the oldest queued mean. Both sides of the
// block idle and stall at random. The restart threshold is reprogrammed
// between phases, including zero and full scale.
// ----------------------------------------------------------------------------
module tb_current_moving_average;
    timeunit 1ns;
    timeprecision 1ps;

    import cma_pkg::*;

    localparam int WINDOW        = 60;
    localparam int PRESSURE_HOLD = 300;   // cycles the sink refuses results
    localparam int SETTLE_CYCLES = 40;    // longer than one divide

    // ------------------------------------------------------------------------
    // Mean tracker: mirrors the block state and holds the means still owed
    // ------------------------------------------------------------------------
    class mean_checker;
        sample_t ring [WINDOW];
        int      running_sum;
        int      fill_count;
        bit      ring_full;
        int      last_mean;
        thresh_t threshold;
        sample_t means_due [$];
        int      errors   = 0;
        int      checked  = 0;
        int      restarts = 0;
        int      wraps    = 0;

        function new();
            running_sum = 0;
            fill_count  = 0;
            ring_full   = 1'b0;
            last_mean   = 0;
            threshold   = THR_RESET;
        endfunction

        function void set_threshold(thresh_t t);
            threshold = t;
        endfunction

        function int pending();
            return means_due.size();
        endfunction

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        // Next running mean for one sample; updates the mirrored state.
        function sample_t predict_mean(sample_t s);
            int v;
            int thr;
            int oldest;
            v   = s;
            thr = threshold;
            if (magnitude(last_mean) < thr && magnitude(v) > thr)
            begin
                // wake-up from near zero: drop the window, pass sample through
                fill_count  = 0;
                ring_full   = 1'b0;
                running_sum = 0;
                last_mean   = v;
                restarts++;
            end
            else if (ring_full)
            begin
                if (fill_count >= WINDOW)
                begin
                    fill_count = 0;
                    wraps++;
                end
                oldest           = ring[fill_count];
                ring[fill_count] = s;
                fill_count++;
                running_sum += v - oldest;
                last_mean    = running_sum / WINDOW;
            end
            else
            begin
                ring[fill_count] = s;
                fill_count++;
                running_sum += v;
                last_mean    = running_sum / fill_count;
                if (fill_count >= WINDOW)
                    ring_full = 1'b1;
            end
            return sample_t'(last_mean);
        endfunction

        function void take_sample(sample_t s);
            means_due.push_back(predict_mean(s));
        endfunction

        function void check_mean(sample_t got);
            sample_t want;
            if (means_due.size() == 0)
            begin
                errors++;
                $error("average_ma: expected none, actual %0d", got);
                return;
            end
            want = means_due.pop_front();
            checked++;
            if (got !== want)
            begin
                errors++;
                $error("average_ma: expected %0d, actual %0d", want, got);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and bench state
    // ------------------------------------------------------------------------
    logic    clk = 1'b0;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    sample_t current_ma;
    logic    out_valid;
    logic    out_stall;
    sample_t average_ma;
    logic    cfg_wr_en;
    thresh_t cfg_wr_data;

    bit tx_burst;       // sender offers items back to back
    bit rx_burst;       // sink takes results without stalling
    bit pressure_req;   // asks the sink for one long hold-off
    int samples_sent = 0;
    int settings_used = 1;

    mean_checker sb = new();

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    current_moving_average #(
        .WINDOW(WINDOW)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .current_ma (current_ma),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .average_ma (average_ma),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // ------------------------------------------------------------------------
    // Monitor: both handshakes sampled on the rising edge. The result is
    // checked first; an item accepted on the same edge cannot be its source
    // since an accepted item passes through S_READ and S_OUT before its result is registered.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_mean(average_ma);
        if (in_valid && !in_stall)
            sb.take_sample(current_ma);
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // One item: optional idle gap, then hold it until the block takes it.
    // Valid stays high between back-to-back items.
    task automatic send_sample(input sample_t v);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        current_ma <= v;
        do @(posedge clk); while (in_stall);
        samples_sent++;
    endtask

    // Drop valid and wait until every queued mean has come back; the block
    // is idle then, since each item yields exactly one result.
    task automatic drain_means();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Single-cycle register write, only issued while the block is idle.
    task automatic program_threshold(input thresh_t t);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= t;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_threshold(t);
        settings_used++;
    endtask

    // Value around a center with uniform spread, saturated to 16 bits.
    function automatic sample_t shaped_sample(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return sample_t'(v);
    endfunction

    // Random traffic in sessions. Most sessions are a wake-up sample (above
    // threshold) followed by an active stretch, some long enough to fill and
    // wrap the ring. Quiet runs pull the mean under the threshold so that
    // later wake-ups restart the window. Raw noise fills the rest.
    task automatic stream_phase(input int budget);
        int sent;
        int kind;
        int len;
        int lvl;
        int jit;
        int thr;
        int m;
        sent = 0;
        while (sent < budget)
        begin
            thr      = sb.threshold;
            kind     = $urandom_range(0, 9);
            tx_burst = ($urandom_range(0, 3) == 0);
            if (kind < 6)
            begin
                // wake-up edge; -32768 is the only choice at full scale
                m = $urandom_range(thr + 1, 32768);
                if (m == 32768 || $urandom_range(0, 1) == 1)
                    send_sample(sample_t'(-m));
                else
                    send_sample(sample_t'(m));
                sent++;
                len = ($urandom_range(0, 2) == 0) ? $urandom_range(WINDOW, 2 * WINDOW + 10)
                                                 : $urandom_range(1, 40);
                case ($urandom_range(0, 4))
                    0, 1:
                    begin
                        // hovers around the threshold: frequent restarts
                        lvl = shaped_sample(0, 2 * thr + 1);
                        jit = $urandom_range(0, 3 * thr + 50);
                    end
                    2, 3:
                    begin
                        lvl = shaped_sample(0, 32767);
                        jit = $urandom_range(0, 3000);
                    end
                    default:
                    begin
                        // pinned at full scale: largest sums through a wrap
                        lvl = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
                        jit = $urandom_range(0, 3);
                        len = $urandom_range(WINDOW, 2 * WINDOW + 10);
                    end
                endcase
                if (len > budget - sent)
                    len = budget - sent;
                repeat (len)
                begin
                    send_sample(shaped_sample(lvl, jit));
                    sent++;
                end
            end
            else if (kind < 8)
            begin
                // quiet current, magnitude never above the threshold
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(WINDOW, WINDOW + 10)
                                                 : $urandom_range(1, 15);
                if (len > budget - sent)
                    len = budget - sent;
                repeat (len)
                begin
                    send_sample(shaped_sample(0, thr));
                    sent++;
                end
            end
            else
            begin
                len = $urandom_range(1, 10);
                if (len > budget - sent)
                    len = budget - sent;
                repeat (len)
                begin
                    send_sample(sample_t'($urandom));
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sink side: random stall before each result, with runs of no stall.
    // One long hold-off on request lets the block back up into its input.
    // ------------------------------------------------------------------------
    initial
    begin : sink
        int hold;
        out_stall = 1'b0;
        rx_burst  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 24) == 0)
                rx_burst = !rx_burst;
            if (pressure_req)
            begin
                hold         = PRESSURE_HOLD;
                pressure_req = 1'b0;
            end
            else
            begin
                hold = rx_burst ? 0 : $urandom_range(0, 9);
            end
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int opening [$];
        int full_scale [$];
        in_valid     = 1'b0;
        current_ma   = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        tx_burst     = 1'b0;
        pressure_req = 1'b0;
        rst_n        = 1'b0;

        // At the reset threshold of 50: samples exactly at the threshold do
        // not restart, one above does; a mean exactly at the threshold blocks
        // a restart; -32768 restarts with magnitude 32768; mixed full-scale
        // sums check truncation toward zero on both signs.
        opening    = '{0, 50, 51, -50, -51, -1, -32768, 32767, -32768, -3,
                       32767, -32768, 100, -100};
        // At full-scale threshold only -32768 can wake the window.
        full_scale = '{32767, -32768, -32768, 32767};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (opening[i])
            send_sample(sample_t'(opening[i]));
        stream_phase(150);
        drain_means();

        // restart can never fire with a zero threshold
        program_threshold('0);
        stream_phase(100);
        drain_means();

        program_threshold('1);
        foreach (full_scale[i])
            send_sample(sample_t'(full_scale[i]));
        stream_phase(90);
        drain_means();

        // mid-range threshold, with the sink backing the block up
        program_threshold(thresh_t'($urandom_range(1, 32766)));
        pressure_req = 1'b1;
        stream_phase(100);
        drain_means();

        program_threshold(thresh_t'(1));
        stream_phase(80);
        drain_means();

        program_threshold(THR_RESET);
        stream_phase(80);
        drain_means();

        // catch any stray result after the last expected one
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Run: %0d samples under %0d threshold settings, zero and full scale included.",
                 samples_sent, settings_used);
        $display("Averages compared: %0d, window restarts: %0d, ring wraps: %0d.",
                 sb.checked, sb.restarts, sb.wraps);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin : watchdog
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
